[rtl/core/assert_macros.svh]
// assertion macros for the rtl core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/prls_pkg.sv]
// types and constants of the paged ring log store
// no dependencies
package prls_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned LIMIT_W    = 11;
    localparam int unsigned COUNT_W    = 12;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned ERASED_W   = 3;

    localparam logic [SAMPLE_W-1:0] ERASED_WORD = 16'hFFFF;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 11'd2000;

    typedef enum logic [1:0] {
        ACT_APPEND       = 2'd0,
        ACT_RESET_CURSOR = 2'd1,
        ACT_READ_NEXT    = 2'd2,
        ACT_RECOVER      = 2'd3
    } t_action;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WIPED = 2'd2;

    typedef struct packed {
        logic [1:0]          action;
        logic [SAMPLE_W-1:0] sample;
    } t_in_word;

    typedef struct packed {
        logic [SAMPLE_W-1:0] read_value;
        logic [COUNT_W-1:0]  sample_count;
        logic [STATUS_W-1:0] status;
        logic [ERASED_W-1:0] pages_erased;
    } t_out_word;

endpackage

[rtl/core/paged_ring_log_store.sv]
// paged ring log store: circular sample log in a page-erased memory
// depends on prls_pkg and assert_macros.svh
//
// One command word is taken when start is high and busy is low; each command
// gives one result word, shown for one cycle with o_strobe, which the receiver
// must take. After reset the memory is swept to the erased value, one word a
// cycle, with busy high until the sweep ends; the limit register can be
// written at any time. The store is one memory with one write and one
// registered read port. Read next reads the word through that port; append
// writes the sample, then drops the oldest entries while the count is over
// the limit, erasing each page the tail leaves, or the whole store when head
// and tail share that page. Recover reads each word scanned forward to the
// head and backward to the tail, then enforces the limit as append does.
`include "assert_macros.svh"

module paged_ring_log_store import prls_pkg::*; #(
    parameter int unsigned PAGE_WORDS = 512,
    parameter int unsigned PAGE_COUNT = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_word           i_word,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    output logic               o_strobe,
    output t_out_word          o_word
);

    localparam int unsigned STORE_WORDS = PAGE_WORDS * PAGE_COUNT;
    localparam int unsigned IW = $clog2(STORE_WORDS);
    localparam int unsigned PW = $clog2(PAGE_COUNT);
    localparam int unsigned OW = $clog2(PAGE_WORDS);
    localparam int unsigned CW = (IW > LIMIT_W) ? IW : LIMIT_W;

    localparam logic [IW-1:0] LAST_IDX  = IW'(STORE_WORDS - 1);
    localparam logic [PW-1:0] LAST_PG   = PW'(PAGE_COUNT - 1);
    localparam logic [OW-1:0] LAST_OFF  = OW'(PAGE_WORDS - 1);
    localparam logic [IW-1:0] PAGE_LAST = IW'(PAGE_WORDS - 1);
    localparam logic [IW:0]   STORE_EXT = (IW+1)'(STORE_WORDS);
    localparam logic [5:0]    PAGES_ADD = 6'(PAGE_COUNT);

    typedef struct packed {
        logic [IW-1:0] idx;
        logic [PW-1:0] pg;
        logic [OW-1:0] off;
    } t_ptr;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LIMIT  = 9'b000000010,
        S_ERASE  = 9'b000000100,
        S_RDWAIT = 9'b000001000,
        S_FRD    = 9'b000010000,
        S_FCHK   = 9'b000100000,
        S_BRD    = 9'b001000000,
        S_BCHK   = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    function automatic logic [IW-1:0] idx_next(logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic t_ptr ptr_next(t_ptr p);
        t_ptr q;
        if (p.idx == LAST_IDX) begin
            q = '0;
        end else begin
            q.idx = p.idx + 1'b1;
            if (p.off == LAST_OFF) begin
                q.off = '0;
                q.pg  = p.pg + 1'b1;
            end else begin
                q.off = p.off + 1'b1;
                q.pg  = p.pg;
            end
        end
        return q;
    endfunction

    function automatic t_ptr ptr_prev(t_ptr p);
        t_ptr q;
        if (p.idx == '0) begin
            q.idx = LAST_IDX;
            q.pg  = LAST_PG;
            q.off = LAST_OFF;
        end else begin
            q.idx = p.idx - 1'b1;
            if (p.off == '0) begin
                q.off = LAST_OFF;
                q.pg  = p.pg - 1'b1;
            end else begin
                q.off = p.off - 1'b1;
                q.pg  = p.pg;
            end
        end
        return q;
    endfunction

    function automatic logic [ERASED_W-1:0] sat_add(logic [ERASED_W-1:0] a, logic [5:0] b);
        logic [5:0] s;
        s = {3'b000, a} + b;
        return (s > 6'd7) ? 3'd7 : s[2:0];
    endfunction

    logic [SAMPLE_W-1:0] mem [STORE_WORDS];
    logic [SAMPLE_W-1:0] r_rdata;

    t_state              r_state, n_state;
    t_ptr                r_head, n_head;
    t_ptr                r_tail, n_tail;
    t_ptr                r_scan, n_scan;
    logic [IW-1:0]       r_cursor, n_cursor;
    logic [LIMIT_W-1:0]  r_limit;
    logic                r_in_data, n_in_data;
    logic                r_init, n_init;
    logic                r_wipe, n_wipe;
    logic                r_wiped, n_wiped;
    logic                r_rd_empty, n_rd_empty;
    logic [ERASED_W-1:0] r_erased, n_erased;
    logic [SAMPLE_W-1:0] r_value, n_value;
    logic [IW-1:0]       r_ers_addr, n_ers_addr;
    logic [IW-1:0]       r_ers_left, n_ers_left;
    logic                r_strobe, n_strobe;
    t_out_word           r_out, n_out;

    logic                c_mem_we;
    logic [IW-1:0]       c_waddr;
    logic [SAMPLE_W-1:0] c_wdata;
    logic [IW-1:0]       c_raddr;
    logic [IW-1:0]       c_count;
    logic                c_over;
    logic                c_erased;
    logic                c_wipe_go;
    t_ptr                c_tail_nx;

    assign c_count = (r_tail.idx <= r_head.idx) ? (r_head.idx - r_tail.idx)
                   : IW'(STORE_EXT + {1'b0, r_head.idx} - {1'b0, r_tail.idx});
    assign c_over    = (CW'(c_count) > CW'(r_limit)) && (r_tail.idx != r_head.idx);
    assign c_erased  = (r_rdata == ERASED_WORD);
    assign c_tail_nx = ptr_next(r_tail);
    assign c_raddr   = (r_state == S_IDLE) ? idx_next(r_cursor) : r_scan.idx;
    assign busy      = (r_state != S_IDLE);
    assign o_strobe  = r_strobe;
    assign o_word    = r_out;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_scan     = r_scan;
        n_cursor   = r_cursor;
        n_in_data  = r_in_data;
        n_init     = r_init;
        n_wipe     = r_wipe;
        n_wiped    = r_wiped;
        n_rd_empty = r_rd_empty;
        n_erased   = r_erased;
        n_value    = r_value;
        n_ers_addr = r_ers_addr;
        n_ers_left = r_ers_left;
        n_strobe   = 1'b0;
        n_out      = r_out;
        c_mem_we   = 1'b0;
        c_waddr    = r_ers_addr;
        c_wdata    = ERASED_WORD;
        c_wipe_go  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_wiped    = 1'b0;
                    n_rd_empty = 1'b0;
                    n_erased   = '0;
                    n_value    = ERASED_WORD;
                    unique case (i_word.action)
                        ACT_APPEND: begin
                            n_head   = ptr_next(r_head);
                            c_mem_we = 1'b1;
                            c_waddr  = n_head.idx;
                            c_wdata  = i_word.sample;
                            n_state  = S_LIMIT;
                        end
                        ACT_RESET_CURSOR: begin
                            n_cursor = r_tail.idx;
                            n_state  = S_DONE;
                        end
                        ACT_READ_NEXT: begin
                            if (r_cursor != r_head.idx) begin
                                n_cursor = idx_next(r_cursor);
                                n_state  = S_RDWAIT;
                            end else begin
                                n_rd_empty = 1'b1;
                                n_state    = S_DONE;
                            end
                        end
                        ACT_RECOVER: begin
                            n_scan    = '0;
                            n_in_data = 1'b0;
                            n_state   = S_FRD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LIMIT: begin
                if (c_over) begin
                    n_tail = c_tail_nx;
                    if (c_tail_nx.off == '0) begin
                        if (r_head.pg == r_tail.pg) begin
                            c_wipe_go = 1'b1;
                        end else begin
                            n_erased   = sat_add(r_erased, 6'd1);
                            n_ers_addr = r_tail.idx - PAGE_LAST;
                            n_ers_left = PAGE_LAST;
                            n_wipe     = 1'b0;
                            n_state    = S_ERASE;
                        end
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ERASE: begin
                c_mem_we = 1'b1;
                if (r_ers_left == '0) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else if (r_wipe) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LIMIT;
                    end
                end else begin
                    n_ers_addr = r_ers_addr + 1'b1;
                    n_ers_left = r_ers_left - 1'b1;
                end
            end
            S_RDWAIT: begin
                n_value = r_rdata;
                n_state = S_DONE;
            end
            S_FRD: n_state = S_FCHK;
            S_FCHK: begin
                n_in_data = r_in_data | ~c_erased;
                if (c_erased && r_in_data) begin
                    n_head  = ptr_prev(r_scan);
                    n_scan  = ptr_prev(ptr_prev(r_scan));
                    n_state = S_BRD;
                end else if (r_scan.idx == LAST_IDX) begin
                    if (!n_in_data) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_head  = r_scan;
                        n_scan  = ptr_prev(r_scan);
                        n_state = S_BRD;
                    end
                end else begin
                    n_scan  = ptr_next(r_scan);
                    n_state = S_FRD;
                end
            end
            S_BRD: n_state = S_BCHK;
            S_BCHK: begin
                if (c_erased) begin
                    n_tail  = r_scan;
                    n_state = S_LIMIT;
                end else if (r_scan.idx == r_head.idx) begin
                    c_wipe_go = 1'b1;
                end else begin
                    n_scan  = ptr_prev(r_scan);
                    n_state = S_BRD;
                end
            end
            S_DONE: begin
                n_strobe           = 1'b1;
                n_out.read_value   = r_value;
                n_out.sample_count = COUNT_W'(c_count);
                n_out.status       = r_wiped ? ST_WIPED : (r_rd_empty ? ST_EMPTY : ST_OK);
                n_out.pages_erased = r_erased;
                n_state            = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // whole store erase
        if (c_wipe_go) begin
            n_head     = '0;
            n_tail     = '0;
            n_wiped    = 1'b1;
            n_erased   = sat_add(r_erased, PAGES_ADD);
            n_ers_addr = '0;
            n_ers_left = LAST_IDX;
            n_wipe     = 1'b1;
            n_state    = S_ERASE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_mem_we) begin
            mem[c_waddr] <= c_wdata;
        end
        r_rdata <= mem[c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_ERASE;
            r_head     <= '0;
            r_tail     <= '0;
            r_scan     <= '0;
            r_cursor   <= '0;
            r_limit    <= LIMIT_RESET;
            r_in_data  <= 1'b0;
            r_init     <= 1'b1;
            r_wipe     <= 1'b0;
            r_wiped    <= 1'b0;
            r_rd_empty <= 1'b0;
            r_erased   <= '0;
            r_ers_addr <= '0;
            r_ers_left <= LAST_IDX;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_scan     <= n_scan;
            r_cursor   <= n_cursor;
            r_in_data  <= n_in_data;
            r_init     <= n_init;
            r_wipe     <= n_wipe;
            r_wiped    <= n_wiped;
            r_rd_empty <= n_rd_empty;
            r_erased   <= n_erased;
            r_ers_addr <= n_ers_addr;
            r_ers_left <= n_ers_left;
            r_strobe   <= n_strobe;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_out   <= n_out;
    end

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_done_strobe, i_clk, i_rst_n, r_state == S_DONE, o_strobe)
    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    `ASSERT_IMPLIES(a_init_busy, i_clk, i_rst_n, r_init, busy && !o_strobe)

endmodule

[bench/prls_log_mirror.sv]
// prediction and result checking for the paged ring log store testbench
// watches the command, result and limit ports; depends on prls_pkg
// keeps its own copy of the store, head, tail, read cursor and limit
module prls_log_mirror
    import prls_pkg::*;
#(
    parameter int unsigned PAGE_WORDS = 512,
    parameter int unsigned PAGE_COUNT = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  t_in_word           i_word,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic               i_strobe,
    input  t_out_word          i_result,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_WORDS = PAGE_WORDS * PAGE_COUNT;

    logic [SAMPLE_W-1:0] flash [STORE_WORDS];
    int unsigned head_ix;
    int unsigned tail_ix;
    int unsigned cursor_ix;
    int unsigned limit_val;
    int unsigned pages_wiped;
    bit          store_wiped;
    t_out_word   pending_results[$];

    function automatic int unsigned step_ix(input int unsigned ix);
        return (ix + 1 >= STORE_WORDS) ? 0 : ix + 1;
    endfunction

    function automatic int unsigned held_words();
        if (tail_ix <= head_ix) begin
            return head_ix - tail_ix;
        end
        return STORE_WORDS + head_ix - tail_ix;
    endfunction

    task automatic erase_page(input int unsigned page);
        for (int unsigned k = 0; k < PAGE_WORDS; k++) begin
            flash[page * PAGE_WORDS + k] = ERASED_WORD;
        end
        pages_wiped++;
    endtask

    task automatic wipe_store();
        for (int unsigned p = 0; p < PAGE_COUNT; p++) begin
            erase_page(p);
        end
        head_ix = 0;
        tail_ix = 0;
        store_wiped = 1'b1;
    endtask

    task automatic drop_oldest();
        int unsigned old_page;
        if (tail_ix == head_ix) begin
            return;
        end
        old_page = tail_ix / PAGE_WORDS;
        tail_ix = step_ix(tail_ix);
        if (tail_ix / PAGE_WORDS != old_page) begin
            if (head_ix / PAGE_WORDS == old_page) begin
                wipe_store();
            end else begin
                erase_page(old_page);
            end
        end
    endtask

    task automatic trim_to_limit();
        while (held_words() > limit_val && tail_ix != head_ix) begin
            drop_oldest();
        end
    endtask

    // head ends the first written run, tail is the first erased word behind it
    task automatic rescan_store();
        int unsigned t;
        bit in_data;
        bit found;
        in_data = 1'b0;
        found = 1'b0;
        for (int unsigned i = 0; i < STORE_WORDS; i++) begin
            if (flash[i] == ERASED_WORD) begin
                if (in_data) begin
                    head_ix = i - 1;
                    found = 1'b1;
                    break;
                end
            end else begin
                in_data = 1'b1;
            end
        end
        if (!found) begin
            if (!in_data) begin
                head_ix = 0;
                tail_ix = 0;
                return;
            end
            head_ix = STORE_WORDS - 1;
        end
        t = head_ix;
        found = 1'b0;
        do begin
            t = (t == 0) ? STORE_WORDS - 1 : t - 1;
            if (flash[t] == ERASED_WORD) begin
                tail_ix = t;
                found = 1'b1;
                break;
            end
        end while (t != head_ix);
        if (!found) begin
            wipe_store();
            return;
        end
        trim_to_limit();
    endtask

    task automatic log_step(input t_in_word cmd, output t_out_word res);
        logic [SAMPLE_W-1:0] value;
        logic [STATUS_W-1:0] st;
        value = ERASED_WORD;
        st = ST_OK;
        pages_wiped = 0;
        store_wiped = 1'b0;
        case (t_action'(cmd.action))
            ACT_APPEND: begin
                head_ix = step_ix(head_ix);
                flash[head_ix] = cmd.sample;
                trim_to_limit();
            end
            ACT_RESET_CURSOR: begin
                cursor_ix = tail_ix;
            end
            ACT_READ_NEXT: begin
                if (cursor_ix != head_ix) begin
                    cursor_ix = step_ix(cursor_ix);
                    value = flash[cursor_ix];
                end else begin
                    st = ST_EMPTY;
                end
            end
            default: begin
                rescan_store();
            end
        endcase
        if (store_wiped) begin
            st = ST_WIPED;
        end
        res.read_value   = value;
        res.sample_count = COUNT_W'(held_words());
        res.status       = st;
        res.pages_erased = (pages_wiped > 7) ? ERASED_W'(7) : ERASED_W'(pages_wiped);
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        t_out_word made;
        if (!i_rst_n) begin
            for (int unsigned i = 0; i < STORE_WORDS; i++) begin
                flash[i] = ERASED_WORD;
            end
            head_ix = 0;
            tail_ix = 0;
            cursor_ix = 0;
            limit_val = LIMIT_RESET;
            pending_results.delete();
            o_errors = 0;
        end else begin
            if (i_strobe) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result word with none expected, got %h", $time, i_result);
                    o_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_result !== want) begin
                        o_errors++;
                        if (i_result.read_value !== want.read_value) begin
                            $display("%0t: read_value expected %h, got %h", $time,
                                     want.read_value, i_result.read_value);
                        end
                        if (i_result.sample_count !== want.sample_count) begin
                            $display("%0t: sample_count expected %0d, got %0d", $time,
                                     want.sample_count, i_result.sample_count);
                        end
                        if (i_result.status !== want.status) begin
                            $display("%0t: status expected %0d, got %0d", $time,
                                     want.status, i_result.status);
                        end
                        if (i_result.pages_erased !== want.pages_erased) begin
                            $display("%0t: pages_erased expected %0d, got %0d", $time,
                                     want.pages_erased, i_result.pages_erased);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                limit_val = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                log_step(i_word, made);
                pending_results.push_back(made);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

[bench/tb_paged_ring_log_store.sv]
// top of the paged ring log store testbench: clock, reset, commands, verdict
// depends on prls_pkg, paged_ring_log_store and prls_log_mirror
module tb_paged_ring_log_store import prls_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PAGE_WORDS  = 512;
    localparam int unsigned PAGE_COUNT  = 5;
    localparam int          N_RANDOM    = 1900;
    localparam int          STALL_LIMIT = 100000;

    typedef enum int {
        MIX_STREAM,
        MIX_WALK,
        MIX_NOISE
    } t_mix;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    t_in_word           i_word      = '0;
    logic               i_cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wdata = '0;
    logic               o_strobe;
    t_out_word          o_word;
    int                 errors;
    int                 pending;
    bit                 pace        = 1'b1;
    int                 quiet_cycles = 0;

    paged_ring_log_store #(
        .PAGE_WORDS (PAGE_WORDS),
        .PAGE_COUNT (PAGE_COUNT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_word      (i_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_word      (o_word)
    );

    prls_log_mirror #(
        .PAGE_WORDS (PAGE_WORDS),
        .PAGE_COUNT (PAGE_COUNT)
    ) mirror (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_word      (i_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_strobe    (o_strobe),
        .i_result    (o_word),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_strobe) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_paged_ring_log_store: done, errors");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input t_action act, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = pace ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_word <= {act, smp};
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return ERASED_WORD;
        end
        return SAMPLE_W'($urandom);
    endfunction

    function automatic t_action pick_action(input t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_STREAM: begin
                if (r < 88) return ACT_APPEND;
                if (r < 94) return ACT_READ_NEXT;
                if (r < 98) return ACT_RESET_CURSOR;
                return ACT_RECOVER;
            end
            MIX_WALK: begin
                if (r < 35) return ACT_APPEND;
                if (r < 95) return ACT_READ_NEXT;
                if (r < 98) return ACT_RESET_CURSOR;
                return ACT_RECOVER;
            end
            default: begin
                if (r < 32) return ACT_APPEND;
                if (r < 64) return ACT_READ_NEXT;
                if (r < 95) return ACT_RESET_CURSOR;
                return ACT_RECOVER;
            end
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LIMIT_W'(1);
            2, 3, 8: return '1;
            4:       return LIMIT_RESET;
            5, 6:    return LIMIT_W'($urandom_range(1, 2047));
            default: return LIMIT_W'($urandom_range(2, 64));
        endcase
    endfunction

    initial begin
        int   sent;
        int   len;
        t_mix mix;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty store: recover with nothing written, read with nothing left
        send_word(ACT_RECOVER, 16'h0000);
        send_word(ACT_READ_NEXT, 16'hFFFF);
        send_word(ACT_RESET_CURSOR, 16'h1234);
        send_word(ACT_APPEND, 16'h0000);
        send_word(ACT_APPEND, 16'hFFFF);
        send_word(ACT_APPEND, 16'hA5A5);
        send_word(ACT_APPEND, 16'h5A5A);
        send_word(ACT_RESET_CURSOR, 16'h0000);
        repeat (5) send_word(ACT_READ_NEXT, 16'h0000);
        send_word(ACT_RECOVER, 16'hFFFF);
        // tight limit drops the oldest, read cursor goes stale
        set_limit(LIMIT_W'(1));
        send_word(ACT_APPEND, 16'h8001);
        send_word(ACT_APPEND, 16'h7FFE);
        send_word(ACT_READ_NEXT, 16'h0000);
        set_limit('0);
        send_word(ACT_APPEND, 16'hC3C3);
        send_word(ACT_RECOVER, 16'h0000);
        send_word(ACT_RESET_CURSOR, 16'h0000);
        send_word(ACT_READ_NEXT, 16'h0000);

        sent = 0;
        while (sent < N_RANDOM) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: mix = MIX_STREAM;
                5, 6, 7:       mix = MIX_WALK;
                default:       mix = MIX_NOISE;
            endcase
            pace = ($urandom_range(0, 9) < 7);
            len = (mix == MIX_NOISE) ? $urandom_range(20, 60) : $urandom_range(60, 240);
            if (len > N_RANDOM - sent) begin
                len = N_RANDOM - sent;
            end
            set_limit(pick_limit());
            if (mix == MIX_WALK) begin
                send_word(ACT_RESET_CURSOR, pick_sample());
                sent++;
            end
            repeat (len) begin
                send_word(pick_action(mix), pick_sample());
                sent++;
            end
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb_paged_ring_log_store: done, clean");
        end else begin
            $display("tb_paged_ring_log_store: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/prls_pkg.sv
rtl/core/paged_ring_log_store.sv
bench/prls_log_mirror.sv
bench/tb_paged_ring_log_store.sv
